// ===== src/eoos_pkg.sv =====
// Package for the even/odd ordered sorter: sizes, controller/datapath
// command and status structs, and the ordering function.
// No dependencies.
package eoos_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int VALUE_BITS = 31;
  localparam int PORT_W     = 31;
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [PORT_W-1:0]     port_val_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // Controller to datapath
  typedef struct packed {
    logic ins;    // insert the input value into the cell chain
    logic shift;  // pop the head cell into the result registers
  } eoos_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_one;  // exactly one value left in the chain
  } eoos_sts_t;

  // Bring a port value to the internal width
  function automatic val_t to_val(input port_val_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[VALUE_BITS-1:0];
  endfunction

  // Bring an internal value back to the port width
  function automatic port_val_t to_port(input val_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[PORT_W-1:0];
  endfunction

  // True when a must come out before b: evens ascending, then odds descending
  function automatic logic goes_before(input val_t a, input val_t b);
    logic res;
    if (a[0] != b[0]) begin
      res = !a[0];
    end else if (!a[0]) begin
      res = (a < b);
    end else begin
      res = (a > b);
    end
    return res;
  endfunction

endpackage

// ===== src/even_odd_ordered_sorter_core.sv =====
// Top level of the even/odd ordered sorter: controller plus datapath.
// Depends on eoos_pkg, eoos_ctrl and eoos_datapath.
//
// Usage:
//   Input: drive value_i and last_in_i with start high; the item transfers
//   at a rising edge where start is high and busy is low. Every item is
//   placed into an insertion cell chain on its transfer edge, so a batch streams
//   in at one item per cycle.
//   Output: after the item flagged last transfers, busy goes high and the
//   whole batch comes out, one result per cycle on out_strobe_o: even
//   values ascending, then odd values descending, last_out_o on the final
//   one, overflow_o set on every result when more than 64 items arrived
//   (the extra items are dropped).
//   Emission: the state register enters emission on the last item's
//   transfer, and the first result is then registered from the head cell;
//   busy stays high until all held items have left through the single
//   pop path out of the head cell. The next batch may start while the final
//   result is still on the ports.
//   The receiver cannot stall: each result is valid for one cycle only.
//   Reset: asynchronous, active low; it empties the chain and clears the
//   internal overflow flag. Cell contents and result registers are not reset.
module even_odd_ordered_sorter_core
  import eoos_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  port_val_t value_i,
  input  logic      last_in_i,
  output logic      out_strobe_o,
  output port_val_t sorted_value_o,
  output logic      last_out_o,
  output logic      overflow_o
);

  eoos_cmd_t cmd;
  eoos_sts_t sts;

  eoos_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .last_in_i    (last_in_i),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .busy         (busy),
    .out_strobe_o (out_strobe_o)
  );

  eoos_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .value_i        (value_i),
    .sts_o          (sts),
    .sorted_value_o (sorted_value_o),
    .last_out_o     (last_out_o),
    .overflow_o     (overflow_o)
  );

endmodule

// ===== src/eoos_ctrl.sv =====
// Controller of the even/odd ordered sorter: collect and emit states.
// Depends on eoos_pkg.
module eoos_ctrl
  import eoos_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      last_in_i,
  input  eoos_sts_t sts_i,
  output eoos_cmd_t cmd_o,
  output logic      busy,
  output logic      out_strobe_o
);

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   strobe_q;

  // Decode commands from state and request
  always_comb begin
    cmd_o.ins   = 1'b0;
    cmd_o.shift = 1'b0;
    state_d     = state_q;
    unique case (state_q)
      ST_COLLECT: begin
        cmd_o.ins = start;
        if (start && last_in_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.last_one) begin
          state_d = ST_COLLECT;
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  // Hold state and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_COLLECT;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= cmd_o.shift;
    end
  end

  assign busy         = (state_q == ST_EMIT);
  assign out_strobe_o = strobe_q;

endmodule

// ===== src/eoos_datapath.sv =====
// Datapath of the even/odd ordered sorter: an insertion cell chain kept in
// output order, item count, overflow flag and result registers.
// Depends on eoos_pkg.
module eoos_datapath
  import eoos_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  eoos_cmd_t cmd_i,
  input  port_val_t value_i,
  output eoos_sts_t sts_o,
  output port_val_t sorted_value_o,
  output logic      last_out_o,
  output logic      overflow_o
);

  val_t      cell_q [MAX_ITEMS];
  cnt_t      count_q;
  logic      ovf_q;
  port_val_t res_val_q;
  logic      res_last_q;
  logic      res_ovf_q;

  val_t                 new_val;
  logic                 full;
  logic [MAX_ITEMS-1:0] ins_w;
  logic [MAX_ITEMS-1:0] prev_ins;
  val_t                 prev_val [MAX_ITEMS];

  // Find where the new value goes: every held cell it must precede
  always_comb begin
    new_val = to_val(value_i);
    full    = (count_q == CNT_W'(MAX_ITEMS));
    for (int i = 0; i < MAX_ITEMS; i++) begin
      ins_w[i] = (CNT_W'(i) < count_q) && goes_before(new_val, cell_q[i]);
    end
    prev_ins[0] = 1'b0;
    prev_val[0] = new_val;
    for (int i = 1; i < MAX_ITEMS; i++) begin
      prev_ins[i] = ins_w[i-1];
      prev_val[i] = cell_q[i-1];
    end
  end

  // Advance the cell chain: pop toward the head, or open a slot and insert
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      for (int i = 0; i < MAX_ITEMS - 1; i++) begin
        cell_q[i] <= cell_q[i+1];
      end
    end else if (cmd_i.ins && !full) begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
        if (ins_w[i] || (CNT_W'(i) == count_q)) begin
          cell_q[i] <= prev_ins[i] ? prev_val[i] : new_val;
        end
      end
    end
  end

  // Track fill level and dropped items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.shift) begin
      count_q <= count_q - CNT_W'(1);
      if (count_q == CNT_W'(1)) begin
        ovf_q <= 1'b0;
      end
    end else if (cmd_i.ins) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  // Load the result registers from the head cell
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      res_val_q  <= to_port(cell_q[0]);
      res_last_q <= (count_q == CNT_W'(1));
      res_ovf_q  <= ovf_q;
    end
  end

  assign sts_o.last_one = (count_q == CNT_W'(1));
  assign sorted_value_o = res_val_q;
  assign last_out_o     = res_last_q;
  assign overflow_o     = res_ovf_q;

endmodule

// ===== src/eoos_checker.sv =====
// Port-level checker for the even/odd ordered sorter, bound to the top.
// Depends on eoos_pkg and even_odd_ordered_sorter_core.
module eoos_checker
  import eoos_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input port_val_t value_i,
  input logic      last_in_i,
  input logic      out_strobe_o,
  input port_val_t sorted_value_o,
  input logic      last_out_o,
  input logic      overflow_o
);

  // A batch end starts emission
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_in_i) |=> busy)
    else $error("busy not raised after last item transfer");

  // Results come only out of an emission
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> $past(busy))
    else $error("result strobe without emission");

  // Results of one batch are back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && !last_out_o) |=> out_strobe_o)
    else $error("gap inside a batch of results");

  // Overflow flag stays the same over a batch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && !last_out_o) |=> (overflow_o == $past(overflow_o)))
    else $error("overflow flag changed inside a batch");

  // Emission ends exactly with the final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (out_strobe_o && last_out_o))
    else $error("busy dropped without final result");

endmodule

bind even_odd_ordered_sorter_core eoos_checker u_eoos_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .value_i        (value_i),
  .last_in_i      (last_in_i),
  .out_strobe_o   (out_strobe_o),
  .sorted_value_o (sorted_value_o),
  .last_out_o     (last_out_o),
  .overflow_o     (overflow_o)
);
